/* rtl/acwa_pkg.sv */
// ----------------------------------------------------------------------------
// ARP cache with aging: shared definitions
// Widths, opcodes and the slot record shared by the controller and the store.
// ----------------------------------------------------------------------------
`default_nettype none

package acwa_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   localparam int KIND_W  = 2;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int STAMP_W = 32;
   localparam int LIMIT_W = 16;
   localparam int USE_W   = 5;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd60;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;

   typedef struct packed {
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_entry;
      logic [IDX_W-1:0] rd_addr;
   } store_req_type;

endpackage

`default_nettype wire

/* rtl/acwa_store.sv */
// ----------------------------------------------------------------------------
// ARP cache slot store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acwa_store (
   input  wire logic                   clock,
   input  wire acwa_pkg::store_req_type store_req,
   output      acwa_pkg::entry_type     rd_entry
);

   acwa_pkg::entry_type slot_mem [acwa_pkg::ENTRIES];
   acwa_pkg::entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         slot_mem[store_req.wr_addr] <= store_req.wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry_ff <= slot_mem[store_req.rd_addr];
   end

   assign rd_entry = rd_entry_ff;

endmodule

`default_nettype wire

/* rtl/acwa_ctrl.sv */
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequencer that walks the slot store for aging, search and oldest selection.
// ----------------------------------------------------------------------------
`default_nettype none

module acwa_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output      logic                             req_ready,
   input  wire logic [acwa_pkg::KIND_W-1:0]      req_kind,
   input  wire logic [acwa_pkg::IP_W-1:0]        req_ip_address,
   input  wire logic [acwa_pkg::MAC_W-1:0]       req_mac_address,
   output      logic                             rsp_valid,
   input  wire logic                             rsp_ready,
   output      logic                             rsp_hit,
   output      logic [acwa_pkg::MAC_W-1:0]       rsp_found_mac,
   output      logic                             rsp_evicted,
   output      logic [acwa_pkg::USE_W-1:0]       rsp_entries_in_use,
   input  wire logic                             csr_wr_en,
   input  wire logic [acwa_pkg::LIMIT_W-1:0]     csr_wr_data,
   output      acwa_pkg::store_req_type          store_req,
   input  wire acwa_pkg::entry_type              rd_entry
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SW_ADDR,
      ST_SW_CHK,
      ST_SW_MOVE,
      ST_FD_ADDR,
      ST_FD_CHK,
      ST_OL_ADDR,
      ST_OL_CHK,
      ST_EVICT,
      ST_EV_MOVE,
      ST_APPEND,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   logic [acwa_pkg::CNT_W-1:0]         count_ff;
   logic [acwa_pkg::CNT_W-1:0]         idx_ff;
   logic [acwa_pkg::STAMP_W-1:0]       now_ff;
   logic [acwa_pkg::LIMIT_W-1:0]       limit_ff;
   logic [acwa_pkg::KIND_W-1:0]        kind_ff;
   logic [acwa_pkg::IP_W-1:0]          ip_ff;
   logic [acwa_pkg::MAC_W-1:0]         mac_ff;
   logic                               hit_ff;
   logic                               evict_ff;
   logic [acwa_pkg::MAC_W-1:0]         found_ff;
   logic [acwa_pkg::IDX_W-1:0]         old_idx_ff;
   logic [acwa_pkg::STAMP_W-1:0]       old_stamp_ff;
   logic                               rsp_valid_ff;
   logic                               rsp_hit_ff;
   logic [acwa_pkg::MAC_W-1:0]         rsp_found_mac_ff;
   logic                               rsp_evicted_ff;
   logic [acwa_pkg::USE_W-1:0]         rsp_entries_ff;

   logic [acwa_pkg::CNT_W-1:0]         last_cnt;
   logic [acwa_pkg::CNT_W-1:0]         idx_next;
   logic [acwa_pkg::STAMP_W-1:0]       age;
   logic                               aged_out;
   logic                               ip_match;
   acwa_pkg::entry_type                new_entry;

   assign last_cnt  = count_ff - acwa_pkg::CNT_W'(1);
   assign idx_next  = idx_ff + acwa_pkg::CNT_W'(1);
   // Age wraps modulo 2^32 like the seconds counter itself.
   assign age       = now_ff - rd_entry.stamp;
   assign aged_out  = age > acwa_pkg::STAMP_W'(limit_ff);
   assign ip_match  = rd_entry.ip == ip_ff;
   assign new_entry = '{ip: ip_ff, mac: mac_ff, stamp: now_ff};

   always_comb begin
      store_req          = '0;
      store_req.rd_addr  = idx_ff[acwa_pkg::IDX_W-1:0];
      store_req.wr_entry = new_entry;
      unique case (state_ff)
         ST_SW_CHK, ST_EVICT: begin
            // Fetch the last entry in case it has to fill a vacated slot.
            store_req.rd_addr = last_cnt[acwa_pkg::IDX_W-1:0];
         end
         ST_SW_MOVE: begin
            store_req.wr_en    = 1'b1;
            store_req.wr_addr  = idx_ff[acwa_pkg::IDX_W-1:0];
            store_req.wr_entry = rd_entry;
         end
         ST_EV_MOVE: begin
            store_req.wr_en    = 1'b1;
            store_req.wr_addr  = old_idx_ff;
            store_req.wr_entry = rd_entry;
         end
         ST_FD_CHK: begin
            store_req.wr_en   = ip_match && (kind_ff == acwa_pkg::KIND_INSERT);
            store_req.wr_addr = idx_ff[acwa_pkg::IDX_W-1:0];
         end
         ST_APPEND: begin
            store_req.wr_en   = 1'b1;
            store_req.wr_addr = count_ff[acwa_pkg::IDX_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         limit_ff     <= acwa_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         // In ST_DONE the result register is reloaded below instead.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  kind_ff  <= req_kind;
                  ip_ff    <= req_ip_address;
                  mac_ff   <= req_mac_address;
                  hit_ff   <= 1'b0;
                  evict_ff <= 1'b0;
                  found_ff <= '0;
                  idx_ff   <= '0;
                  if (req_kind == acwa_pkg::KIND_TICK) begin
                     now_ff   <= now_ff + acwa_pkg::STAMP_W'(1);
                     state_ff <= ST_DONE;
                  end else if (req_kind == acwa_pkg::KIND_INSERT ||
                               req_kind == acwa_pkg::KIND_LOOKUP) begin
                     state_ff <= ST_SW_ADDR;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SW_ADDR: begin
               if (idx_ff >= count_ff) begin
                  idx_ff   <= '0;
                  state_ff <= ST_FD_ADDR;
               end else begin
                  state_ff <= ST_SW_CHK;
               end
            end
            ST_SW_CHK: begin
               if (aged_out) begin
                  if (idx_next < count_ff) begin
                     state_ff <= ST_SW_MOVE;
                  end else begin
                     count_ff <= last_cnt;
                     state_ff <= ST_SW_ADDR;
                  end
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_SW_ADDR;
               end
            end
            ST_SW_MOVE: begin
               // The moved entry sits at the same index and is checked again.
               count_ff <= last_cnt;
               state_ff <= ST_SW_ADDR;
            end
            ST_FD_ADDR: begin
               if (idx_ff >= count_ff) begin
                  if (kind_ff == acwa_pkg::KIND_LOOKUP) begin
                     state_ff <= ST_DONE;
                  end else if (count_ff >= acwa_pkg::CNT_W'(acwa_pkg::ENTRIES)) begin
                     idx_ff   <= '0;
                     state_ff <= ST_OL_ADDR;
                  end else begin
                     state_ff <= ST_APPEND;
                  end
               end else begin
                  state_ff <= ST_FD_CHK;
               end
            end
            ST_FD_CHK: begin
               if (ip_match) begin
                  hit_ff <= 1'b1;
                  if (kind_ff == acwa_pkg::KIND_LOOKUP) begin
                     found_ff <= rd_entry.mac;
                  end
                  state_ff <= ST_DONE;
               end else begin
                  idx_ff   <= idx_next;
                  state_ff <= ST_FD_ADDR;
               end
            end
            ST_OL_ADDR: begin
               if (idx_ff >= count_ff) begin
                  state_ff <= ST_EVICT;
               end else begin
                  state_ff <= ST_OL_CHK;
               end
            end
            ST_OL_CHK: begin
               // Strict less-than keeps the lowest index on equal stamps.
               if (idx_ff == '0 || rd_entry.stamp < old_stamp_ff) begin
                  old_stamp_ff <= rd_entry.stamp;
                  old_idx_ff   <= idx_ff[acwa_pkg::IDX_W-1:0];
               end
               idx_ff   <= idx_next;
               state_ff <= ST_OL_ADDR;
            end
            ST_EVICT: begin
               evict_ff <= 1'b1;
               if (old_idx_ff == last_cnt[acwa_pkg::IDX_W-1:0]) begin
                  count_ff <= last_cnt;
                  state_ff <= ST_APPEND;
               end else begin
                  state_ff <= ST_EV_MOVE;
               end
            end
            ST_EV_MOVE: begin
               count_ff <= last_cnt;
               state_ff <= ST_APPEND;
            end
            ST_APPEND: begin
               count_ff <= count_ff + acwa_pkg::CNT_W'(1);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_hit_ff       <= hit_ff;
                  rsp_found_mac_ff <= found_ff;
                  rsp_evicted_ff   <= evict_ff;
                  rsp_entries_ff   <= acwa_pkg::USE_W'(count_ff);
                  state_ff         <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign req_ready          = state_ff == ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = rsp_hit_ff;
   assign rsp_found_mac      = rsp_found_mac_ff;
   assign rsp_evicted        = rsp_evicted_ff;
   assign rsp_entries_in_use = rsp_entries_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= acwa_pkg::CNT_W'(acwa_pkg::ENTRIES))
      else $error("entry count above table size");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind == acwa_pkg::KIND_TICK)
      |=> now_ff == $past(now_ff) + acwa_pkg::STAMP_W'(1))
      else $error("tick did not advance the seconds counter");

   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVICT |-> count_ff == acwa_pkg::CNT_W'(acwa_pkg::ENTRIES))
      else $error("eviction with free slots");

   a_hit_xor_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_evicted_ff))
      else $error("result reports both a hit and an eviction");

   a_mac_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hit_ff || rsp_found_mac_ff == '0))
      else $error("nonzero MAC without a hit");

endmodule

`default_nettype wire

/* rtl/arp_cache_with_aging_core.sv */
// ----------------------------------------------------------------------------
// ARP cache with aging: top level
// IPv4-to-MAC cache whose entries expire against a tick-driven seconds clock.
// ----------------------------------------------------------------------------
// Flow, accept to result valid: a tick or unused beat goes straight to the result stage. Insert and
//   lookup first age every slot, refilling each aged entry from the end, then search the slots;
//   an insert miss appends, and on a full table first scans for the oldest entry and evicts it,
//   refilling its slot from the end unless it is the last one.
// Throughput: one beat in flight; the next is taken once its result is registered.
// Reset: synchronous; clears entry count and seconds, sets the limit to 60, keeps slots.
`default_nettype none

module arp_cache_with_aging_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [acwa_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [acwa_pkg::IP_W-1:0]    req_ip_address,
   input  wire logic [acwa_pkg::MAC_W-1:0]   req_mac_address,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_hit,
   output      logic [acwa_pkg::MAC_W-1:0]   rsp_found_mac,
   output      logic                         rsp_evicted,
   output      logic [acwa_pkg::USE_W-1:0]   rsp_entries_in_use,
   input  wire logic                         csr_wr_en,
   input  wire logic [acwa_pkg::LIMIT_W-1:0] csr_wr_data
);

   acwa_pkg::store_req_type store_req;
   acwa_pkg::entry_type     rd_entry;

   acwa_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_ip_address     (req_ip_address),
      .req_mac_address    (req_mac_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hit            (rsp_hit),
      .rsp_found_mac      (rsp_found_mac),
      .rsp_evicted        (rsp_evicted),
      .rsp_entries_in_use (rsp_entries_in_use),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .store_req          (store_req),
      .rd_entry           (rd_entry)
   );

   acwa_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_entry  (rd_entry)
   );

endmodule

`default_nettype wire
